@@ design/sbe_pkg.sv @@
// Shared opcodes, value kinds, status codes and Q32.32 helpers for the bytecode executor.
package sbe_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 256;

    localparam logic [3:0] OP_RETURN  = 4'd0;
    localparam logic [3:0] OP_CONST   = 4'd1;
    localparam logic [3:0] OP_NEGATE  = 4'd2;
    localparam logic [3:0] OP_ADD     = 4'd3;
    localparam logic [3:0] OP_SUB     = 4'd4;
    localparam logic [3:0] OP_MUL     = 4'd5;
    localparam logic [3:0] OP_DIV     = 4'd6;
    localparam logic [3:0] OP_NIL     = 4'd7;
    localparam logic [3:0] OP_TRUE    = 4'd8;
    localparam logic [3:0] OP_FALSE   = 4'd9;
    localparam logic [3:0] OP_NOT     = 4'd10;
    localparam logic [3:0] OP_EQUAL   = 4'd11;
    localparam logic [3:0] OP_GREATER = 4'd12;
    localparam logic [3:0] OP_LESS    = 4'd13;

    localparam logic [1:0] K_NIL   = 2'd0;
    localparam logic [1:0] K_BOOL  = 2'd1;
    localparam logic [1:0] K_NUM   = 2'd2;
    localparam logic [1:0] K_EMPTY = 2'd3;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_RET  = 3'd1;
    localparam logic [2:0] ST_OPND = 3'd2;
    localparam logic [2:0] ST_RHS  = 3'd3;
    localparam logic [2:0] ST_LHS  = 3'd4;
    localparam logic [2:0] ST_OVF  = 3'd5;
    localparam logic [2:0] ST_UNF  = 3'd6;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    function automatic logic [63:0] mag_of(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic [63:0] sat_from_mag(input logic [63:0] m, input logic neg,
                                                 input logic ovf);
        logic [63:0] r;
        if (!neg) r = (ovf || m > MAX64) ? MAX64 : m;
        else      r = (ovf || m > SIGN64) ? SIGN64 : (64'd0 - m);
        return r;
    endfunction

    function automatic logic [63:0] q_neg(input logic [63:0] a);
        return (a == SIGN64) ? MAX64 : (64'd0 - a);
    endfunction

    function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SIGN64 : MAX64;
        return r;
    endfunction

    function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? SIGN64 : MAX64;
        return r;
    endfunction

    function automatic logic signed_less(input logic [63:0] a, input logic [63:0] b);
        return (a ^ SIGN64) < (b ^ SIGN64);
    endfunction

endpackage

@@ design/sbe_muldiv.sv @@
// Iterative Q32.32 multiply (four 32x32 partial products) and restoring divide.
module sbe_muldiv (
    input  logic             aclk,
    input  logic             aresetn,
    input  sbe_pkg::md_req_t req,
    input  logic [63:0]      lhs,
    input  logic [63:0]      rhs,
    output logic             done,
    output logic [63:0]      result
);

    logic         busy_reg, fin_reg, is_div_reg, neg_reg, ovf_reg, done_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  ua_reg, ub_reg, rem_reg, q_reg, dvd_reg, result_reg;
    logic [127:0] acc_reg;

    logic [31:0]  mx, my;
    logic [63:0]  prod;
    logic [127:0] prod_sh;
    logic [63:0]  rem_sh, rem_new, q_new;
    logic         carry;

    // Pick and scale one partial product
    always_comb begin
        mx = cnt_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
        my = cnt_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
        prod = 64'(mx) * 64'(my);
        case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   prod_sh = {64'd0, prod};
            2'b11:   prod_sh = {prod, 64'd0};
            default: prod_sh = {32'd0, prod, 32'd0};
        endcase
    end

    // One restoring divide step
    always_comb begin
        carry   = rem_reg[63];
        rem_sh  = {rem_reg[62:0], dvd_reg[63]};
        q_new   = {q_reg[62:0], 1'b0};
        rem_new = rem_sh;
        if (carry || rem_sh >= ub_reg) begin
            rem_new  = rem_sh - ub_reg;
            q_new[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            is_div_reg <= req.is_div;
            neg_reg    <= lhs[63] ^ rhs[63];
            ua_reg     <= sbe_pkg::mag_of(lhs);
            ub_reg     <= sbe_pkg::mag_of(rhs);
            dvd_reg    <= sbe_pkg::mag_of(lhs);
            cnt_reg    <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            ovf_reg    <= 1'b0;
            if (req.is_div && rhs == 64'd0) begin
                // divide by zero saturates by the dividend sign
                result_reg <= (lhs == 64'd0) ? 64'd0 :
                              (lhs[63] ? sbe_pkg::SIGN64 : sbe_pkg::MAX64);
                done_reg   <= 1'b1;
            end else begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
            if (is_div_reg)
                result_reg <= sbe_pkg::sat_from_mag(q_reg, neg_reg, ovf_reg);
            else
                result_reg <= sbe_pkg::sat_from_mag(acc_reg[95:32], neg_reg,
                                                    acc_reg[127:96] != 32'd0);
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (is_div_reg) begin
                    if (q_reg[63]) ovf_reg <= 1'b1;
                    q_reg   <= q_new;
                    rem_reg <= rem_new;
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    if (cnt_reg == 7'd95) begin
                        busy_reg <= 1'b0;
                        fin_reg  <= 1'b1;
                    end
                end else begin
                    acc_reg <= acc_reg + prod_sh;
                    if (cnt_reg == 7'd3) begin
                        busy_reg <= 1'b0;
                        fin_reg  <= 1'b1;
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ design/stack_bytecode_executor_core.sv @@
// Top level of the stack bytecode executor: sequencer around the stack memory.
// Throughput: one request at a time, taken the cycle after the result is registered.
// The stack memory port (one read, one write per cycle) sets the fetch sequence length.
// Reset: synchronous, active low; clears the depth and control state, leaving the
// stack memory contents undefined (only entries below the depth are used).
module stack_bytecode_executor_core #(
    parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_op,
    input  logic [1:0]  s_const_kind,
    input  logic [63:0] s_const_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_top_kind,
    output logic [63:0] m_top_payload,
    output logic [8:0]  m_stack_depth
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH_B, S_FETCH_A, S_EXEC, S_MD_WAIT, S_FINISH
    } state_t;

    state_t      state_reg;
    logic [3:0]  op_reg;
    logic [1:0]  ck_reg;
    logic [63:0] cp_reg;
    logic [DW-1:0] depth_reg, new_depth_reg;
    logic [1:0]  b_kind_reg, a_kind_reg, res_kind_reg;
    logic [63:0] b_pay_reg, a_pay_reg, res_pay_reg;
    logic [2:0]  res_status_reg;
    logic        wr_en_reg;
    logic [AW-1:0] waddr_reg;
    logic [65:0] rdata_reg;
    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [1:0]  m_kind_reg;
    logic [63:0] m_pay_reg;
    logic [DW-1:0] m_depth_reg;

    logic [65:0] stack_mem [STACK_DEPTH];

    logic [AW-1:0] raddr;
    logic          out_free, mem_we;

    // Execute decode
    logic          has1, has2, full, ex_md, ex_div;
    logic [2:0]    ex_status;
    logic [1:0]    ex_kind;
    logic [63:0]   ex_pay;
    logic [DW-1:0] ex_depth;
    logic          ex_wr;
    logic [AW-1:0] ex_waddr;
    logic [AW-1:0] addr_top, addr_sec, addr_push;

    sbe_pkg::md_req_t md_req;
    logic          md_done;
    logic [63:0]   md_result;
    logic [31:0]   depth_wide;

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign mem_we   = (state_reg == S_FINISH) && out_free && wr_en_reg;
    assign raddr    = (state_reg == S_IDLE) ? AW'(depth_reg - DW'(1))
                                            : AW'(depth_reg - DW'(2));

    // Stack memory: registered read, single write
    always_ff @(posedge aclk) begin
        rdata_reg <= stack_mem[raddr];
        if (mem_we) stack_mem[waddr_reg] <= {res_kind_reg, res_pay_reg};
    end

    always_comb begin
        has1      = depth_reg != '0;
        has2      = depth_reg > DW'(1);
        full      = depth_reg >= DW'(STACK_DEPTH);
        addr_top  = AW'(depth_reg - DW'(1));
        addr_sec  = AW'(depth_reg - DW'(2));
        addr_push = AW'(depth_reg);
        ex_status = sbe_pkg::ST_OK;
        ex_kind   = has1 ? b_kind_reg : sbe_pkg::K_EMPTY;
        ex_pay    = has1 ? b_pay_reg : 64'd0;
        ex_depth  = depth_reg;
        ex_wr     = 1'b0;
        ex_waddr  = addr_top;
        ex_md     = 1'b0;
        ex_div    = 1'b0;
        unique case (op_reg) inside
            sbe_pkg::OP_RETURN: begin
                if (!has1) begin
                    ex_status = sbe_pkg::ST_UNF;
                end else begin
                    ex_status = sbe_pkg::ST_RET;
                    ex_depth  = depth_reg - DW'(1);
                end
            end
            sbe_pkg::OP_CONST, sbe_pkg::OP_NIL, sbe_pkg::OP_TRUE, sbe_pkg::OP_FALSE: begin
                if (full) begin
                    ex_status = sbe_pkg::ST_OVF;
                end else begin
                    ex_wr    = 1'b1;
                    ex_waddr = addr_push;
                    ex_depth = depth_reg + DW'(1);
                    if (op_reg == sbe_pkg::OP_NIL) begin
                        ex_kind = sbe_pkg::K_NIL;  ex_pay = 64'd0;
                    end else if (op_reg == sbe_pkg::OP_TRUE) begin
                        ex_kind = sbe_pkg::K_BOOL; ex_pay = 64'd1;
                    end else if (op_reg == sbe_pkg::OP_FALSE) begin
                        ex_kind = sbe_pkg::K_BOOL; ex_pay = 64'd0;
                    end else if (ck_reg == sbe_pkg::K_BOOL) begin
                        ex_kind = sbe_pkg::K_BOOL; ex_pay = {63'd0, cp_reg != 64'd0};
                    end else if (ck_reg == sbe_pkg::K_NUM) begin
                        ex_kind = sbe_pkg::K_NUM;  ex_pay = cp_reg;
                    end else begin
                        ex_kind = sbe_pkg::K_NIL;  ex_pay = 64'd0;
                    end
                end
            end
            sbe_pkg::OP_NEGATE: begin
                if (!has1) ex_status = sbe_pkg::ST_UNF;
                else if (b_kind_reg != sbe_pkg::K_NUM) ex_status = sbe_pkg::ST_OPND;
                else begin
                    ex_wr  = 1'b1;
                    ex_pay = sbe_pkg::q_neg(b_pay_reg);
                end
            end
            sbe_pkg::OP_NOT: begin
                if (!has1) ex_status = sbe_pkg::ST_UNF;
                else begin
                    ex_wr   = 1'b1;
                    ex_kind = sbe_pkg::K_BOOL;
                    ex_pay  = {63'd0, b_kind_reg == sbe_pkg::K_NIL ||
                               (b_kind_reg == sbe_pkg::K_BOOL && b_pay_reg == 64'd0)};
                end
            end
            sbe_pkg::OP_EQUAL: begin
                if (!has2) ex_status = sbe_pkg::ST_UNF;
                else begin
                    ex_wr    = 1'b1;
                    ex_waddr = addr_sec;
                    ex_depth = depth_reg - DW'(1);
                    ex_kind  = sbe_pkg::K_BOOL;
                    ex_pay   = {63'd0, b_kind_reg == a_kind_reg && b_pay_reg == a_pay_reg};
                end
            end
            sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
            sbe_pkg::OP_GREATER, sbe_pkg::OP_LESS: begin
                if (!has2) ex_status = sbe_pkg::ST_UNF;
                else if (b_kind_reg != sbe_pkg::K_NUM) ex_status = sbe_pkg::ST_RHS;
                else if (a_kind_reg != sbe_pkg::K_NUM) ex_status = sbe_pkg::ST_LHS;
                else begin
                    ex_wr    = 1'b1;
                    ex_waddr = addr_sec;
                    ex_depth = depth_reg - DW'(1);
                    ex_kind  = sbe_pkg::K_NUM;
                    ex_md    = (op_reg == sbe_pkg::OP_MUL) || (op_reg == sbe_pkg::OP_DIV);
                    ex_div   = op_reg == sbe_pkg::OP_DIV;
                    if (op_reg == sbe_pkg::OP_ADD)
                        ex_pay = sbe_pkg::q_add(a_pay_reg, b_pay_reg);
                    else if (op_reg == sbe_pkg::OP_SUB)
                        ex_pay = sbe_pkg::q_sub(a_pay_reg, b_pay_reg);
                    else if (op_reg == sbe_pkg::OP_GREATER) begin
                        ex_kind = sbe_pkg::K_BOOL;
                        ex_pay  = {63'd0, sbe_pkg::signed_less(b_pay_reg, a_pay_reg)};
                    end else if (op_reg == sbe_pkg::OP_LESS) begin
                        ex_kind = sbe_pkg::K_BOOL;
                        ex_pay  = {63'd0, sbe_pkg::signed_less(a_pay_reg, b_pay_reg)};
                    end
                end
            end
            default: ;
        endcase
        // Errors clear the stack
        if (ex_status != sbe_pkg::ST_OK && ex_status != sbe_pkg::ST_RET) begin
            ex_kind  = sbe_pkg::K_EMPTY;
            ex_pay   = 64'd0;
            ex_depth = '0;
            ex_wr    = 1'b0;
            ex_md    = 1'b0;
        end
    end

    assign md_req.start  = (state_reg == S_EXEC) && ex_md;
    assign md_req.is_div = ex_div;

    sbe_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .lhs     (a_pay_reg),
        .rhs     (b_pay_reg),
        .done    (md_done),
        .result  (md_result)
    );

    // Sequencer: fetch operands, execute, write back and register the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
            wr_en_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FINISH) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_op;
                        ck_reg    <= s_const_kind;
                        cp_reg    <= s_const_payload;
                        state_reg <= S_FETCH_B;
                    end
                end
                S_FETCH_B: begin
                    b_kind_reg <= rdata_reg[65:64];
                    b_pay_reg  <= rdata_reg[63:0];
                    state_reg  <= S_FETCH_A;
                end
                S_FETCH_A: begin
                    a_kind_reg <= rdata_reg[65:64];
                    a_pay_reg  <= rdata_reg[63:0];
                    state_reg  <= S_EXEC;
                end
                S_EXEC: begin
                    res_status_reg <= ex_status;
                    res_kind_reg   <= ex_kind;
                    res_pay_reg    <= ex_pay;
                    new_depth_reg  <= ex_depth;
                    wr_en_reg      <= ex_wr;
                    waddr_reg      <= ex_waddr;
                    state_reg      <= ex_md ? S_MD_WAIT : S_FINISH;
                end
                S_MD_WAIT: begin
                    if (md_done) begin
                        res_pay_reg <= md_result;
                        state_reg   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_kind_reg   <= res_kind_reg;
                        m_pay_reg    <= res_pay_reg;
                        m_depth_reg  <= new_depth_reg;
                        depth_reg    <= new_depth_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign depth_wide    = 32'(m_depth_reg);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_kind    = m_kind_reg;
    assign m_top_payload = m_pay_reg;
    assign m_stack_depth = depth_wide[8:0];

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");

    a_error_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == sbe_pkg::ST_OPND || m_status == sbe_pkg::ST_RHS ||
                     m_status == sbe_pkg::ST_LHS || m_status == sbe_pkg::ST_OVF ||
                     m_status == sbe_pkg::ST_UNF))
        |-> (m_stack_depth == 9'd0 && m_top_kind == sbe_pkg::K_EMPTY))
        else $error("error result without cleared stack");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (32'(waddr_reg) < STACK_DEPTH))
        else $error("stack write out of range");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the stack bytecode executor core.
`timescale 1ns / 100ps

module tb_top;

    // Unassigned opcode, executes as a no-op
    localparam logic [3:0] OP_SPARE = 4'd15;

    typedef struct {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [63:0] payload;
        logic [8:0]  depth;
    } vm_result_t;

    // Executor model and queue of pending results
    class vm_scoreboard;
        logic [1:0]  kinds [sbe_pkg::STACK_DEPTH_DEF];
        logic [63:0] vals [sbe_pkg::STACK_DEPTH_DEF];
        int unsigned sp;
        vm_result_t  pending_q[$];
        int          errors;

        function vm_result_t fault(logic [2:0] st);
            vm_result_t r;
            sp = 0;
            r.status = st; r.kind = sbe_pkg::K_EMPTY; r.payload = '0; r.depth = '0;
            return r;
        endfunction

        function logic [63:0] sat(logic [63:0] m, logic neg, logic ovf);
            if (!neg) return (ovf || m > sbe_pkg::MAX64) ? sbe_pkg::MAX64 : m;
            return (ovf || m > sbe_pkg::SIGN64) ? sbe_pkg::SIGN64 : (64'd0 - m);
        endfunction

        function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            logic [63:0] ua, ub;
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            p = {64'd0, ua} * {64'd0, ub};
            return sat(p[95:32], a[63] ^ b[63], p[127:96] != 32'd0);
        endfunction

        function logic [63:0] div_q(logic [63:0] a, logic [63:0] b);
            logic [127:0] q;
            logic [63:0] ua, ub;
            if (b == 64'd0)
                return (a == 64'd0) ? 64'd0 : (a[63] ? sbe_pkg::SIGN64 : sbe_pkg::MAX64);
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = {32'd0, ua, 32'd0} / {64'd0, ub};
            return sat(q[63:0], a[63] ^ b[63], q[127:64] != 64'd0);
        endfunction

        function logic [63:0] add_q(logic [63:0] a, logic [63:0] b, logic sub);
            logic [63:0] r;
            r = sub ? a - b : a + b;
            if ((sub ? a[63] != b[63] : a[63] == b[63]) && r[63] != a[63])
                r = a[63] ? sbe_pkg::SIGN64 : sbe_pkg::MAX64;
            return r;
        endfunction

        function void push(logic [1:0] k, logic [63:0] p);
            kinds[sp] = k; vals[sp] = p; sp++;
        endfunction

        function void note_request(logic [3:0] op, logic [1:0] ck, logic [63:0] cp);
            vm_result_t r;
            logic [63:0] a, b, v;
            logic lt_ab, lt_ba;
            r.status = sbe_pkg::ST_OK;
            case (op) inside
                sbe_pkg::OP_RETURN: begin
                    if (sp < 1) begin pending_q.push_back(fault(sbe_pkg::ST_UNF)); return; end
                    sp--;
                    r.status = sbe_pkg::ST_RET; r.kind = kinds[sp]; r.payload = vals[sp];
                    r.depth = 9'(sp);
                    pending_q.push_back(r);
                    return;
                end
                sbe_pkg::OP_CONST, sbe_pkg::OP_NIL, sbe_pkg::OP_TRUE,
                sbe_pkg::OP_FALSE: begin
                    if (sp >= sbe_pkg::STACK_DEPTH_DEF) begin
                        pending_q.push_back(fault(sbe_pkg::ST_OVF)); return;
                    end
                    if (op == sbe_pkg::OP_NIL) push(sbe_pkg::K_NIL, 64'd0);
                    else if (op == sbe_pkg::OP_TRUE) push(sbe_pkg::K_BOOL, 64'd1);
                    else if (op == sbe_pkg::OP_FALSE) push(sbe_pkg::K_BOOL, 64'd0);
                    else if (ck == sbe_pkg::K_BOOL)
                        push(sbe_pkg::K_BOOL, {63'd0, cp != 64'd0});
                    else if (ck == sbe_pkg::K_NUM) push(sbe_pkg::K_NUM, cp);
                    else push(sbe_pkg::K_NIL, 64'd0);
                end
                sbe_pkg::OP_NEGATE: begin
                    if (sp < 1) begin pending_q.push_back(fault(sbe_pkg::ST_UNF)); return; end
                    if (kinds[sp-1] != sbe_pkg::K_NUM) begin
                        pending_q.push_back(fault(sbe_pkg::ST_OPND)); return;
                    end
                    v = vals[sp-1];
                    vals[sp-1] = (v == sbe_pkg::SIGN64) ? sbe_pkg::MAX64 : -v;
                end
                sbe_pkg::OP_NOT: begin
                    if (sp < 1) begin pending_q.push_back(fault(sbe_pkg::ST_UNF)); return; end
                    v = {63'd0, (kinds[sp-1] == sbe_pkg::K_NIL) ||
                         (kinds[sp-1] == sbe_pkg::K_BOOL && vals[sp-1] == 64'd0)};
                    kinds[sp-1] = sbe_pkg::K_BOOL; vals[sp-1] = v;
                end
                sbe_pkg::OP_EQUAL: begin
                    if (sp < 2) begin pending_q.push_back(fault(sbe_pkg::ST_UNF)); return; end
                    v = {63'd0, (kinds[sp-1] == kinds[sp-2]) && (vals[sp-1] == vals[sp-2])};
                    sp -= 2;
                    push(sbe_pkg::K_BOOL, v);
                end
                sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
                sbe_pkg::OP_GREATER, sbe_pkg::OP_LESS: begin
                    if (sp < 2) begin pending_q.push_back(fault(sbe_pkg::ST_UNF)); return; end
                    if (kinds[sp-1] != sbe_pkg::K_NUM) begin
                        pending_q.push_back(fault(sbe_pkg::ST_RHS)); return;
                    end
                    if (kinds[sp-2] != sbe_pkg::K_NUM) begin
                        pending_q.push_back(fault(sbe_pkg::ST_LHS)); return;
                    end
                    b = vals[sp-1]; a = vals[sp-2];
                    lt_ab = $signed(a) < $signed(b);
                    lt_ba = $signed(b) < $signed(a);
                    sp -= 2;
                    case (op)
                        sbe_pkg::OP_ADD:     push(sbe_pkg::K_NUM, add_q(a, b, 1'b0));
                        sbe_pkg::OP_SUB:     push(sbe_pkg::K_NUM, add_q(a, b, 1'b1));
                        sbe_pkg::OP_MUL:     push(sbe_pkg::K_NUM, mul_q(a, b));
                        sbe_pkg::OP_DIV:     push(sbe_pkg::K_NUM, div_q(a, b));
                        sbe_pkg::OP_GREATER: push(sbe_pkg::K_BOOL, {63'd0, lt_ba});
                        default:             push(sbe_pkg::K_BOOL, {63'd0, lt_ab});
                    endcase
                end
                default: ;
            endcase
            r.depth = 9'(sp);
            if (sp == 0) begin r.kind = sbe_pkg::K_EMPTY; r.payload = '0; end
            else begin r.kind = kinds[sp-1]; r.payload = vals[sp-1]; end
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [1:0] k, logic [63:0] p,
                                   logic [8:0] d);
            vm_result_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result: status %0d", st);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st); errors++;
            end
            if (k !== e.kind) begin
                $error("top_kind: expected %0d, got %0d", e.kind, k); errors++;
            end
            if (p !== e.payload) begin
                $error("top_payload: expected %h, got %h", e.payload, p); errors++;
            end
            if (d !== e.depth) begin
                $error("stack_depth: expected %0d, got %0d", e.depth, d); errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_op;
    logic [1:0]  s_const_kind;
    logic [63:0] s_const_payload;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [1:0]  m_top_kind;
    logic [63:0] m_top_payload;
    logic [8:0]  m_stack_depth;

    vm_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    stack_bytecode_executor_core u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: stall at random, check each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_top_kind, m_top_payload, m_stack_depth);
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand_num();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return sbe_pkg::SIGN64;
            2: return sbe_pkg::MAX64;
            3: return 64'($signed($urandom_range(40) - 20)) << 32;
            4: return 64'($signed(int'($urandom_range(2000)) - 1000)) << 24;
            default: return {{32{1'b0}}, $urandom} ^ {64{1'($urandom_range(1))}};
        endcase
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(logic [3:0] op, logic [1:0] ck, logic [63:0] cp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_const_kind <= ck;
        s_const_payload <= cp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, ck, cp);
    endtask

    task automatic push_num(logic [63:0] v);
        send_request(sbe_pkg::OP_CONST, sbe_pkg::K_NUM, v);
    endtask

    // Drop the request line and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_q.size() != 0);
    endtask

    // Random request mix, biased towards numeric work at moderate depth
    task automatic random_request();
        logic [3:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_request(sbe_pkg::OP_CONST, (($urandom_range(9) == 0) ? 2'($urandom_range(3))
                         : sbe_pkg::K_NUM), rand_num());
            return;
        end
        else if (pick < 75) op = 4'(sbe_pkg::OP_ADD + $urandom_range(3));
        else if (pick < 85) op = 4'(sbe_pkg::OP_GREATER + $urandom_range(1));
        else op = 4'($urandom_range(15));
        if (op == sbe_pkg::OP_DIV && $urandom_range(3) == 0) begin
            push_num(rand_num());
            push_num($urandom_range(1) ? 64'd0 : rand_num());
        end
        send_request(op, 2'($urandom_range(3)), {$urandom, $urandom});
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = '0;
        s_const_kind = '0;
        s_const_payload = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: underflow on an empty stack, every non-numeric push form, equal, not, negate of a bool
        send_request(sbe_pkg::OP_RETURN, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_ADD, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_CONST, sbe_pkg::K_BOOL, 64'hFFFF_0000_0000_0000);
        send_request(sbe_pkg::OP_CONST, sbe_pkg::K_EMPTY, sbe_pkg::MAX64);
        send_request(sbe_pkg::OP_CONST, sbe_pkg::K_NIL, 64'd5);
        send_request(sbe_pkg::OP_NIL, sbe_pkg::K_NUM, 64'd0);
        send_request(sbe_pkg::OP_TRUE, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_FALSE, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_EQUAL, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_NOT, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_NEGATE, sbe_pkg::K_NIL, 64'd0);
        // Saturation at the extremes, division by zero, type errors
        push_num(sbe_pkg::SIGN64);
        send_request(sbe_pkg::OP_NEGATE, sbe_pkg::K_NIL, 64'd0);
        push_num(sbe_pkg::MAX64);
        send_request(sbe_pkg::OP_ADD, sbe_pkg::K_NIL, 64'd0);
        push_num(64'd0);
        send_request(sbe_pkg::OP_DIV, sbe_pkg::K_NIL, 64'd0);
        push_num(sbe_pkg::SIGN64);
        send_request(sbe_pkg::OP_MUL, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_TRUE, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_SUB, sbe_pkg::K_NIL, 64'd0);
        push_num(64'd0);
        push_num(64'd0);
        send_request(sbe_pkg::OP_DIV, sbe_pkg::K_NIL, 64'd0);
        send_request(OP_SPARE, sbe_pkg::K_NIL, 64'd0);
        send_request(sbe_pkg::OP_NIL, sbe_pkg::K_NIL, 64'd0);
        push_num(64'd1);
        send_request(sbe_pkg::OP_LESS, sbe_pkg::K_NIL, 64'd0);
        drain();

        // Fill the stack to overflow, refill it with numbers, then unwind with returns
        repeat (sbe_pkg::STACK_DEPTH_DEF + 1)
            send_request(sbe_pkg::OP_TRUE, sbe_pkg::K_NIL, 64'd0);
        repeat (sbe_pkg::STACK_DEPTH_DEF) push_num(rand_num());
        repeat (sbe_pkg::STACK_DEPTH_DEF + 1)
            send_request(sbe_pkg::OP_RETURN, sbe_pkg::K_NIL, 64'd0);

        // Random phases with different idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            repeat (120) random_request();
            drain();
        end

        // Fill and overflow once more under stalls to drive bits high
        repeat (sbe_pkg::STACK_DEPTH_DEF + 1) push_num({$urandom, $urandom});
        repeat (20) random_request();

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
